>>> rtl/core/rsc_pkg.sv
// Package for the radix string converter: command record, codes and sizes.
// No dependencies; used by every module of the block.
`default_nettype none
package rsc_pkg;

    localparam int MAX_DIGITS  = 64;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int COUNT_W     = 7;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 72;

    localparam logic [1:0] OP_CONVERT = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    typedef struct packed {
        logic [1:0]  op;
        logic        err;
        logic [63:0] value;
        logic [6:0]  width;
        logic [5:0]  base_out;
    } cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/rsc_front.sv
// Front end: accepts input transactions, accumulates runs and classifies commands.
// Depends on rsc_pkg.
`default_nettype none
module rsc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [95:0]        s_tdata,
    input  wire logic [1:0]         s_tuser,
    input  wire logic               s_tlast,
    input  wire logic               q_full,
    output logic                    q_push,
    output rsc_pkg::cmd_t           q_cmd
);
    import rsc_pkg::*;

    logic [63:0]        acc_reg, acc_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               sign_reg, sign_next;
    logic               ovf_reg, ovf_next;

    logic [5:0]  base_in, base_out;
    logic [6:0]  width;
    logic [7:0]  digit_char;
    logic [63:0] signed_value;
    logic        accept;
    logic        bit_in;
    logic [COUNT_W-1:0] cnt_inc;
    logic [63:0] acc_rd, rd_val, mag;
    logic        sign_rd;
    logic [9:0]  dval;
    logic [69:0] prod;
    logic [71:0] sum;
    logic        ovf_cv;

    assign base_in      = s_tdata[5:0];
    assign base_out     = s_tdata[11:6];
    assign width        = s_tdata[18:12];
    assign digit_char   = s_tdata[26:19];
    assign signed_value = s_tdata[90:27];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        bit_in  = (digit_char == CHAR_ONE);
        cnt_inc = (cnt_reg == {COUNT_W{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
        sign_rd = (cnt_reg == '0) ? bit_in : sign_reg;
        acc_rd  = {acc_reg[62:0], bit_in};
        rd_val  = acc_rd;
        if (sign_rd && (cnt_inc < COUNT_W'(64)))
        begin
            rd_val = acc_rd | (~64'd0 << cnt_inc[5:0]);
        end
        dval = (digit_char > CHAR_NINE) ? ({2'b00, digit_char} - 10'd55)
                                        : ({2'b00, digit_char} - 10'd48);
        prod = {6'd0, acc_reg} * {64'd0, base_in};
        sum  = {2'b00, prod} + {{62{dval[9]}}, dval};
        ovf_cv = ovf_reg || (prod[69:63] != 7'd0) || sum[71] || (sum[70:63] != 8'd0);
        mag = signed_value[63] ? ~signed_value : signed_value;

        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        sign_next = sign_reg;
        ovf_next  = ovf_reg;
        q_push    = 1'b0;
        q_cmd     = '0;
        q_cmd.op  = s_tuser;

        if (accept)
        begin
            case (s_tuser)
                OP_CONVERT:
                begin
                    if (!ovf_cv)
                    begin
                        acc_next = sum[63:0];
                    end
                    ovf_next = ovf_cv;
                    cnt_next = cnt_inc;
                    if (s_tlast)
                    begin
                        q_push         = 1'b1;
                        q_cmd.err      = ovf_cv || (base_out < 6'd2);
                        q_cmd.value    = ovf_cv ? acc_reg : sum[63:0];
                        q_cmd.base_out = base_out;
                        acc_next  = '0;
                        cnt_next  = '0;
                        sign_next = 1'b0;
                        ovf_next  = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    q_push      = 1'b1;
                    q_cmd.value = signed_value;
                    q_cmd.width = width;
                    q_cmd.err   = (width < 7'd2) || (width > 7'(MAX_DIGITS))
                                  || ((mag >> (width - 7'd1)) != 64'd0);
                end
                OP_READ:
                begin
                    acc_next  = acc_rd;
                    sign_next = sign_rd;
                    cnt_next  = cnt_inc;
                    if (s_tlast)
                    begin
                        q_push      = 1'b1;
                        q_cmd.value = rd_val;
                        acc_next  = '0;
                        cnt_next  = '0;
                        sign_next = 1'b0;
                        ovf_next  = 1'b0;
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            sign_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            sign_reg <= sign_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/rsc_queue.sv
// Two-entry command queue between front end and back end.
// Depends on rsc_pkg.
`default_nettype none
module rsc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rsc_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output rsc_pkg::cmd_t      head_cmd,
    output logic               full,
    output logic               empty
);
    import rsc_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/rsc_back.sv
// Back end: executes commands, radix division, digit buffer and result register.
// Depends on rsc_pkg.
`default_nettype none
module rsc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire rsc_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [71:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);
    import rsc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_FETCH  = 6'b000100,
        ST_SEND   = 6'b001000,
        ST_WBITS  = 6'b010000,
        ST_SINGLE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]  digit_mem [MAX_DIGITS];
    logic [5:0]  rd_data_reg;

    logic [63:0] quo_reg, quo_next;
    logic [5:0]  rem_reg, rem_next;
    logic [5:0]  bout_reg, bout_next;
    logic [5:0]  step_reg, step_next;
    logic [DIGIT_IDX_W:0]   ndig_reg, ndig_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]  skind_reg, skind_next;

    logic        ov_reg, ov_next;
    logic [7:0]  oc_reg, oc_next;
    logic [63:0] oval_reg, oval_next;
    logic [1:0]  okind_reg, okind_next;
    logic        olast_reg, olast_next;

    logic        out_free;
    logic [6:0]  trial;
    logic        ge;
    logic [6:0]  trial_sub;
    logic        digit_done;

    assign out_free = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {oval_reg, oc_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[63]};
        ge         = (trial >= {1'b0, bout_reg});
        trial_sub  = trial - {1'b0, bout_reg};
        digit_done = (state_reg == ST_DIV) && (step_reg == 6'd63);

        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        bout_next  = bout_reg;
        step_next  = step_reg;
        ndig_next  = ndig_reg;
        idx_next   = idx_reg;
        skind_next = skind_reg;
        q_pop      = 1'b0;
        ov_next    = ov_reg && !m_tready;
        oc_next    = oc_reg;
        oval_next  = oval_reg;
        okind_next = okind_reg;
        olast_next = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    quo_next   = q_cmd.value;
                    rem_next   = '0;
                    step_next  = '0;
                    ndig_next  = '0;
                    bout_next  = q_cmd.base_out;
                    idx_next   = DIGIT_IDX_W'(q_cmd.width - 7'd1);
                    skind_next = KIND_ERROR;
                    if (q_cmd.err)
                    begin
                        state_next = ST_SINGLE;
                    end
                    else if (q_cmd.op == OP_READ)
                    begin
                        skind_next = KIND_VALUE;
                        state_next = ST_SINGLE;
                    end
                    else if (q_cmd.op == OP_WRITE)
                    begin
                        state_next = ST_WBITS;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? trial_sub[5:0] : trial[5:0];
                quo_next  = {quo_reg[62:0], ge};
                step_next = step_reg + 6'd1;
                if (digit_done)
                begin
                    ndig_next = ndig_reg + 1'b1;
                    rem_next  = '0;
                    if ({quo_reg[62:0], ge} == 64'd0)
                    begin
                        idx_next   = ndig_reg[DIGIT_IDX_W-1:0];
                        state_next = ST_FETCH;
                    end
                    else if (ndig_reg == (DIGIT_IDX_W+1)'(MAX_DIGITS - 1))
                    begin
                        skind_next = KIND_ERROR;
                        quo_next   = '0;
                        state_next = ST_SINGLE;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oc_next    = (rd_data_reg < 6'd10) ? CHAR_ZERO + {2'b00, rd_data_reg}
                                 : CHAR_UPPER_A + {2'b00, rd_data_reg} - 8'd10;
                    oval_next  = '0;
                    okind_next = KIND_CHAR;
                    olast_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_WBITS:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oc_next    = quo_reg[idx_reg] ? CHAR_ONE : CHAR_ZERO;
                    oval_next  = '0;
                    okind_next = KIND_CHAR;
                    olast_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oc_next    = '0;
                    oval_next  = (skind_reg == KIND_VALUE) ? quo_reg : 64'd0;
                    okind_next = skind_reg;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (digit_done)
        begin
            digit_mem[ndig_reg[DIGIT_IDX_W-1:0]] <= ge ? trial_sub[5:0] : trial[5:0];
        end
        if (state_reg == ST_FETCH)
        begin
            rd_data_reg <= digit_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        bout_reg  <= bout_next;
        idx_reg   <= idx_next;
        skind_reg <= skind_next;
        oc_reg    <= oc_next;
        oval_reg  <= oval_next;
        okind_reg <= okind_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ndig_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ndig_reg  <= ndig_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/radix_string_converter_top.sv
// Top level of the radix string converter: front end, command queue, back end.
// Non-final convert/read items update run registers; a write, read or error result
// is queued; a write then emits one character per cycle unless the output stalls.
// Convert emission: digits come from a bit-serial radix divider; each character
// then passes the ST_FETCH and ST_SEND states and the registered digit buffer read.
// Reset (rst_n low, asynchronous) clears run state, queue and output valid.
`default_nettype none
module radix_string_converter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // base_in[5:0], base_out[11:6], width[18:12], digit_char[26:19],
    // signed_value[90:27], zero[95:91]
    input  wire logic [95:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_char[7:0], out_value[71:8]
    output logic [71:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import rsc_pkg::*;

    cmd_t push_cmd, head_cmd;
    logic push, pop, full, empty;

    rsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    rsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (full),
        .empty    (empty)
    );

    rsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (empty),
        .q_cmd    (head_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

>>> rtl/core/rsc_checker.sv
// Port-level checker for the radix string converter, bound to the top level.
// Depends on rsc_pkg and radix_string_converter_top.
`default_nettype none
module rsc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import rsc_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_value_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_VALUE) |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("decoded value not a single result");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ERROR) |-> m_tlast && (m_tdata == 72'd0))
        else $error("error result malformed");

    a_char_novalue: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_CHAR) |-> (m_tdata[71:8] == 64'd0))
        else $error("character result carries a value");

endmodule

bind radix_string_converter_top rsc_checker u_rsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
